// ----- hw/rtl/frustum_cull_test_unit_defines.svh -----
// Assertion macros shared by the frustum culling RTL.
`ifndef FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define FRC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/frc_pkg.sv -----
// Shared constants, operation codes and pipeline types of the frustum culling block.
package frc_pkg;

    // Default configuration.
    localparam int PLANE_COUNT_DEF   = 6;
    localparam int FRACTION_BITS_DEF = 16;

    // Field and datapath widths.
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int COORD_W = 32;
    localparam int HALF_W  = 32;
    localparam int RSQ_W   = 2 * (COORD_W - 1);
    localparam int PROD_W  = 2 * COORD_W;
    localparam int SQ_W    = PROD_W - 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int NORM_W  = PROD_W;
    localparam int MID_W   = PROD_W + 1;
    localparam int WIDE_W  = 2 * NORM_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT  = 2'd1;
    localparam logic [OP_W-1:0] OP_SPHERE = 2'd2;
    localparam logic [OP_W-1:0] OP_BOX    = 2'd3;

    // One beat as it travels along the row of plane cells.
    typedef struct packed {
        logic                valid;
        logic [OP_W-1:0]     operation;
        logic [SLOT_W-1:0]   plane_slot;
        logic [COORD_W-1:0]  first_x;
        logic [COORD_W-1:0]  first_y;
        logic [COORD_W-1:0]  first_z;
        logic [COORD_W-1:0]  second_x;
        logic [COORD_W-1:0]  second_y;
        logic [COORD_W-1:0]  second_z;
        logic [RSQ_W-1:0]    radius_sq;
    } t_item;

    // Running cull verdict handed from cell to cell at the end of each tail.
    typedef struct packed {
        logic valid;
        logic culled;
    } t_acc;

endpackage

// ----- hw/rtl/frc_if.sv -----
// Valid/ready channel interfaces for test beats in and visibility results out.
interface frc_item_if;
    import frc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [SLOT_W-1:0]         plane_slot;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;

    modport source (
        output valid, operation, plane_slot, first_x, first_y, first_z,
               second_x, second_y, second_z,
        input  ready
    );

    modport sink (
        input  valid, operation, plane_slot, first_x, first_y, first_z,
               second_x, second_y, second_z,
        output ready
    );
endinterface

interface frc_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

// ----- hw/rtl/frc_entry.sv -----
// Entry stage: takes input beats, clamps the sphere radius and squares it once.
module frc_entry (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    frc_item_if.sink      i_req,
    output frc_pkg::t_item o_item
);
    import frc_pkg::*;

    logic [COORD_W-2:0] w_radius;
    t_item              n_item;
    t_item              r_item;

    // The whole row moves together, so a beat is taken whenever the row advances out of reset.
    assign i_req.ready = i_en && i_rst_n;

    // A negative radius counts as zero.
    assign w_radius = i_req.second_x[COORD_W-1] ? '0 : i_req.second_x[COORD_W-2:0];

    always_comb begin
        n_item.valid      = i_req.valid;
        n_item.operation  = i_req.operation;
        n_item.plane_slot = i_req.plane_slot;
        n_item.first_x    = i_req.first_x;
        n_item.first_y    = i_req.first_y;
        n_item.first_z    = i_req.first_z;
        n_item.second_x   = i_req.second_x;
        n_item.second_y   = i_req.second_y;
        n_item.second_z   = i_req.second_z;
        n_item.radius_sq  = w_radius * w_radius;
    end

    // Entry register; only the valid flag is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- hw/rtl/frc_cell.sv -----
// One plane cell: holds a plane, forwards beats to its neighbour and tests them in its tail.
`include "frustum_cull_test_unit_defines.svh"

module frc_cell #(
    parameter int INDEX         = 0,
    parameter int FRACTION_BITS = frc_pkg::FRACTION_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  frc_pkg::t_item i_item,
    input  frc_pkg::t_acc  i_acc,
    output frc_pkg::t_item o_item,
    output frc_pkg::t_acc  o_acc
);
    import frc_pkg::*;

    // Plane coefficients a, b, c, d.
    logic signed [COORD_W-1:0] r_a, r_b, r_c, r_d;

    logic                      w_load_hit;
    logic                      w_box;
    logic                      n_test;
    logic signed [COORD_W-1:0] w_vx, w_vy, w_vz;
    logic signed [PROD_W-1:0]  n_pa, n_pb, n_pc;
    logic signed [PROD_W-1:0]  n_sa, n_sb, n_sc;
    logic                      n_cull;

    t_item r_item;
    t_acc  r_acc;

    // Tail stage 1: products and squared normal components.
    logic                      r_v1, r_sph1;
    logic signed [PROD_W-1:0]  r_pa, r_pb, r_pc;
    logic [SQ_W-1:0]           r_sa, r_sb, r_sc;
    logic signed [COORD_W-1:0] r_d1;
    logic [RSQ_W-1:0]          r_r2_1;
    // Tail stage 2: partial sums.
    logic                      r_v2, r_sph2;
    logic signed [SUM_W-1:0]   r_s01, r_s23;
    logic [NORM_W-1:0]         r_n01;
    logic [SQ_W-1:0]           r_nc;
    logic [RSQ_W-1:0]          r_r2_2;
    // Tail stage 3: plane value and squared normal length.
    logic                      r_v3, r_sph3;
    logic signed [SUM_W-1:0]   r_s;
    logic [NORM_W-1:0]         r_n2;
    logic [RSQ_W-1:0]          r_r2_3;
    // Tail stage 4: sign and magnitude.
    logic                      r_v4, r_sph4, r_neg4;
    logic [NORM_W-1:0]         r_mag;
    logic [NORM_W-1:0]         r_n2_4;
    logic [RSQ_W-1:0]          r_r2_4;
    // Tail stage 5: 32 by 32 partial products of both sides of the sphere test.
    logic                      r_v5, r_sph5, r_neg5;
    logic [PROD_W-1:0]         r_pll, r_plh, r_phh;
    logic [PROD_W-1:0]         r_qll, r_qlh;
    logic [RSQ_W-1:0]          r_qhl, r_qhh;
    // Tail stage 6: left side complete, right side half summed.
    logic                      r_v6, r_sph6, r_neg6;
    logic [WIDE_W-1:0]         r_lhs6, r_rbase;
    logic [MID_W-1:0]          r_rmid;
    // Tail stage 7: both sides complete.
    logic                      r_v7, r_sph7, r_neg7;
    logic [WIDE_W-1:0]         r_lhs7, r_rhs;

    // A load for this slot replaces the plane as the beat enters the cell.
    assign w_load_hit = i_en && i_item.valid && (i_item.operation == OP_LOAD)
                        && (int'(i_item.plane_slot) == INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (w_load_hit) begin
            r_a <= $signed(i_item.first_x);
            r_b <= $signed(i_item.first_y);
            r_c <= $signed(i_item.first_z);
            r_d <= $signed(i_item.second_x);
        end
    end

    // Register the beat and forward it to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;

    // For a box, take the corner furthest along the plane normal.
    assign w_box = (i_item.operation == OP_BOX);
    assign w_vx  = (w_box && !r_a[COORD_W-1]) ? $signed(i_item.second_x)
                                              : $signed(i_item.first_x);
    assign w_vy  = (w_box && !r_b[COORD_W-1]) ? $signed(i_item.second_y)
                                              : $signed(i_item.first_y);
    assign w_vz  = (w_box && !r_c[COORD_W-1]) ? $signed(i_item.second_z)
                                              : $signed(i_item.first_z);

    always_comb begin
        n_test = i_item.valid && (i_item.operation inside {OP_POINT, OP_SPHERE, OP_BOX});
    end

    assign n_pa = r_a * w_vx;
    assign n_pb = r_b * w_vy;
    assign n_pc = r_c * w_vz;
    assign n_sa = r_a * r_a;
    assign n_sb = r_b * r_b;
    assign n_sc = r_c * r_c;

    // Arithmetic tail; the whole tail advances with the row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            // Stage 1.
            r_v1   <= n_test;
            r_sph1 <= (i_item.operation == OP_SPHERE);
            r_pa   <= n_pa;
            r_pb   <= n_pb;
            r_pc   <= n_pc;
            r_sa   <= n_sa[SQ_W-1:0];
            r_sb   <= n_sb[SQ_W-1:0];
            r_sc   <= n_sc[SQ_W-1:0];
            r_d1   <= r_d;
            r_r2_1 <= i_item.radius_sq;
            // Stage 2.
            r_v2   <= r_v1;
            r_sph2 <= r_sph1;
            r_s01  <= SUM_W'(r_pa) + SUM_W'(r_pb);
            r_s23  <= SUM_W'(r_pc) + (SUM_W'(r_d1) <<< FRACTION_BITS);
            r_n01  <= NORM_W'(r_sa) + NORM_W'(r_sb);
            r_nc   <= r_sc;
            r_r2_2 <= r_r2_1;
            // Stage 3.
            r_v3   <= r_v2;
            r_sph3 <= r_sph2;
            r_s    <= r_s01 + r_s23;
            r_n2   <= r_n01 + NORM_W'(r_nc);
            r_r2_3 <= r_r2_2;
            // Stage 4.
            r_v4   <= r_v3;
            r_sph4 <= r_sph3;
            r_neg4 <= r_s[SUM_W-1];
            r_mag  <= NORM_W'(-r_s);
            r_n2_4 <= r_n2;
            r_r2_4 <= r_r2_3;
            // Stage 5.
            r_v5   <= r_v4;
            r_sph5 <= r_sph4;
            r_neg5 <= r_neg4;
            r_pll  <= r_mag[HALF_W-1:0] * r_mag[HALF_W-1:0];
            r_plh  <= r_mag[HALF_W-1:0] * r_mag[NORM_W-1:HALF_W];
            r_phh  <= r_mag[NORM_W-1:HALF_W] * r_mag[NORM_W-1:HALF_W];
            r_qll  <= r_r2_4[HALF_W-1:0] * r_n2_4[HALF_W-1:0];
            r_qlh  <= r_r2_4[HALF_W-1:0] * r_n2_4[NORM_W-1:HALF_W];
            r_qhl  <= r_r2_4[RSQ_W-1:HALF_W] * r_n2_4[HALF_W-1:0];
            r_qhh  <= r_r2_4[RSQ_W-1:HALF_W] * r_n2_4[NORM_W-1:HALF_W];
            // Stage 6.
            r_v6    <= r_v5;
            r_sph6  <= r_sph5;
            r_neg6  <= r_neg5;
            r_lhs6  <= {r_phh, r_pll} + (WIDE_W'(r_plh) << (HALF_W + 1));
            r_rbase <= WIDE_W'({r_qhh, r_qll});
            r_rmid  <= MID_W'(r_qlh) + MID_W'(r_qhl);
            // Stage 7.
            r_v7   <= r_v6;
            r_sph7 <= r_sph6;
            r_neg7 <= r_neg6;
            r_lhs7 <= r_lhs6;
            r_rhs  <= r_rbase + (WIDE_W'(r_rmid) << HALF_W);
        end
    end

    // Culled on the negative side; a sphere also needs its centre beyond the radius.
    assign n_cull = r_v7 && r_neg7 && (!r_sph7 || (r_lhs7 > r_rhs));

    // Merge with the verdict of the previous cell, which lines up with this tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.valid <= 1'b0;
        end else if (i_en) begin
            r_acc.valid  <= r_v7;
            r_acc.culled <= i_acc.culled | n_cull;
        end
    end

    assign o_acc = r_acc;

    // A load for this slot lands in the plane registers on the next edge.
    `FRC_ASSERT_NEXT(a_load_writes_plane, w_load_hit, (r_a == $past($signed(i_item.first_x))) && (r_d == $past($signed(i_item.second_x))), "plane load not stored")
    // The verdict from the previous cell arrives together with this cell's tail.
    `FRC_ASSERT_IMPLIES(a_verdict_aligned, (INDEX != 0), (i_acc.valid == r_v7), "cell verdicts out of step")

endmodule

// ----- hw/rtl/frustum_cull_test_unit.sv -----
// Top level of the six-plane view-frustum culling test.
// A row of PLANE_COUNT cells, one per plane, in Q16.16 fixed point. Load beats
// write one plane into its cell as they pass along the row and give no result;
// point, sphere and box beats each give one visible bit, exact with no rounding.
// The block takes one beat per clock unless the output stalls it. A test beat passes
// through one entry stage, one hop per cell ahead of the last, the arithmetic tail
// and verdict register of the last cell, where each 64 by 64 square is split into
// 32 by 32 partial products, and the output register.
// The input stalls only while a result waits at the output and another is
// ready right behind it; every load affects exactly the beats that follow it.
`include "frustum_cull_test_unit_defines.svh"

module frustum_cull_test_unit #(
    parameter int PLANE_COUNT   = frc_pkg::PLANE_COUNT_DEF,
    parameter int FRACTION_BITS = frc_pkg::FRACTION_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    frc_item_if.sink      i_req,
    frc_result_if.source  o_res
);
    import frc_pkg::*;

    logic  w_en;
    t_item w_item [PLANE_COUNT];
    t_acc  w_acc  [PLANE_COUNT+1];
    logic  r_out_valid;
    logic  r_out_visible;
    logic  n_out_valid;
    logic  w_load_out;

    // The row advances unless a result is stuck at the output with another behind it.
    assign w_en = !(r_out_valid && !o_res.ready && w_acc[PLANE_COUNT].valid);

    frc_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (i_req),
        .o_item  (w_item[0])
    );

    // Nothing is culled ahead of the first cell.
    assign w_acc[0] = '0;

    // Row of plane cells.
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        if (g < PLANE_COUNT - 1) begin : g_mid
            frc_cell #(
                .INDEX         (g),
                .FRACTION_BITS (FRACTION_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_item  (w_item[g]),
                .i_acc   (w_acc[g]),
                .o_item  (w_item[g+1]),
                .o_acc   (w_acc[g+1])
            );
        end else begin : g_last
            frc_cell #(
                .INDEX         (g),
                .FRACTION_BITS (FRACTION_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_item  (w_item[g]),
                .i_acc   (w_acc[g]),
                .o_item  (),
                .o_acc   (w_acc[g+1])
            );
        end
    end

    // Output register: loaded when a verdict leaves the row, held until taken.
    assign w_load_out  = w_en && w_acc[PLANE_COUNT].valid;
    assign n_out_valid = w_load_out || (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_visible <= !w_acc[PLANE_COUNT].culled;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.visible = r_out_visible;

    // The input is held back only while the output is blocked.
    `FRC_ASSERT_IMPLIES(a_stall_only_when_blocked, !i_req.ready, o_res.valid && !o_res.ready, "input stalled without a blocked output")
    // A new result only ever comes from a test verdict leaving the row.
    `FRC_ASSERT_IMPLIES(a_result_from_row, $rose(o_res.valid), $past(w_acc[PLANE_COUNT].valid), "result without a verdict")

endmodule

// ----- dv/frustum_cull_test_unit_tb.sv -----
// Self-checking testbench for the six-plane frustum culling block with a built-in visibility predictor.
module frustum_cull_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int PLANES      = PLANE_COUNT_DEF;
    localparam int FRAC        = FRACTION_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 700;

    localparam logic signed [31:0] ONE    = 32'sd1 <<< FRAC;
    localparam logic signed [31:0] S32MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32MIN = 32'sh8000_0000;

    // Plane coefficient indexes within one stored plane.
    localparam int COEF_A = 0;
    localparam int COEF_B = 1;
    localparam int COEF_C = 2;
    localparam int COEF_D = 3;

    // Kinds of plane the random part loads.
    typedef enum int {PLANE_ZERO, PLANE_AXIS, PLANE_NEAR, PLANE_WILD} t_plane_kind;

    // One input beat as queued for the driver.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic signed [31:0] fx, fy, fz, sx, sy, sz;
        bit                wait_drain;
    } t_cull_beat;

    logic i_clk;
    logic i_rst_n;

    frc_item_if   req_if ();
    frc_result_if res_if ();

    frustum_cull_test_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Predictor state and bookkeeping.
    logic signed [31:0] plane_coef [PLANES][4];
    t_cull_beat  pending_beats [$];
    bit          visible_expected [$];
    t_cull_beat  current_beat;
    int unsigned beats_accepted;
    int unsigned loads_sent, ignored_loads;
    int unsigned point_tests, sphere_tests, box_tests;
    int unsigned results_checked, visible_seen, culled_seen;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          hold_done;

    // Exact plane value at a point, scaled by 2^(2*FRAC).
    function automatic logic signed [127:0] plane_value(int p, logic signed [31:0] x,
                                                       logic signed [31:0] y,
                                                       logic signed [31:0] z);
        logic signed [127:0] wa, wb, wc, wd, wx, wy, wz;
        wa = plane_coef[p][COEF_A];
        wb = plane_coef[p][COEF_B];
        wc = plane_coef[p][COEF_C];
        wd = plane_coef[p][COEF_D];
        wx = x;
        wy = y;
        wz = z;
        return wa * wx + wb * wy + wc * wz + (wd <<< FRAC);
    endfunction

    // Visible bit of a test beat against the current plane store.
    function automatic bit predict_visibility(t_cull_beat b);
        logic signed [127:0] s, wa, wb, wc;
        logic [127:0] mag, rad, nsq;
        logic signed [31:0] vx, vy, vz;
        bit culled;
        culled = 1'b0;
        for (int p = 0; p < PLANES; p++) begin
            case (b.op)
                OP_POINT: begin
                    s = plane_value(p, b.fx, b.fy, b.fz);
                    if (s < 0) culled = 1'b1;
                end
                OP_SPHERE: begin
                    s = plane_value(p, b.fx, b.fy, b.fz);
                    if (s < 0) begin
                        // Compare squares so that no root of the normal length is needed.
                        wa = plane_coef[p][COEF_A];
                        wb = plane_coef[p][COEF_B];
                        wc = plane_coef[p][COEF_C];
                        mag = -s;
                        if (b.sx < 0) rad = '0;
                        else rad = b.sx;
                        nsq = wa * wa + wb * wb + wc * wc;
                        if (mag * mag > rad * rad * nsq) culled = 1'b1;
                    end
                end
                default: begin
                    // Positive vertex: max corner where the normal component is not negative.
                    vx = (plane_coef[p][COEF_A] >= 0) ? b.sx : b.fx;
                    vy = (plane_coef[p][COEF_B] >= 0) ? b.sy : b.fy;
                    vz = (plane_coef[p][COEF_C] >= 0) ? b.sz : b.fz;
                    s = plane_value(p, vx, vy, vz);
                    if (s < 0) culled = 1'b1;
                end
            endcase
        end
        return !culled;
    endfunction

    // Update the plane store or record the expected visibility for an accepted beat.
    function automatic void accept_beat(t_cull_beat b);
        if (b.op == OP_LOAD) begin
            loads_sent++;
            if (b.slot < PLANES) begin
                plane_coef[b.slot][COEF_A] = b.fx;
                plane_coef[b.slot][COEF_B] = b.fy;
                plane_coef[b.slot][COEF_C] = b.fz;
                plane_coef[b.slot][COEF_D] = b.sx;
            end else begin
                ignored_loads++;
            end
        end else begin
            visible_expected.push_back(predict_visibility(b));
            case (b.op)
                OP_POINT:  point_tests++;
                OP_SPHERE: sphere_tests++;
                default:   box_tests++;
            endcase
        end
    endfunction

    task automatic queue_beat(logic [OP_W-1:0] op, int slot,
                              logic signed [31:0] fx, logic signed [31:0] fy,
                              logic signed [31:0] fz, logic signed [31:0] sx,
                              logic signed [31:0] sy, logic signed [31:0] sz);
        t_cull_beat b;
        b.op = op;
        b.slot = SLOT_W'(slot);
        b.fx = fx;
        b.fy = fy;
        b.fz = fz;
        b.sx = sx;
        b.sy = sy;
        b.sz = sz;
        b.wait_drain = 1'b0;
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [31:0] rand_within(int unsigned span);
        int v;
        v = int'($urandom_range(2 * span)) - int'(span);
        return v;
    endfunction

    // Mostly coordinates near the origin, sometimes anywhere, sometimes the extremes.
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1:    v = $urandom;
            2:       v = ($urandom_range(1) != 0) ? S32MAX : S32MIN;
            default: v = rand_within(32'd1 << 21);
        endcase
        return v;
    endfunction

    task automatic queue_plane(int slot, t_plane_kind kind);
        logic signed [31:0] c [4];
        int axis;
        c = '{default: '0};
        case (kind)
            PLANE_AXIS: begin
                // Half-space bounding one axis, so a frustum-like box forms around the origin.
                axis = $urandom_range(2);
                c[axis] = ($urandom_range(1) != 0) ? ONE : -ONE;
                c[COEF_D] = $urandom_range(32'd1 << 21);
            end
            PLANE_NEAR: begin
                for (int k = 0; k < 3; k++) c[k] = rand_within(32'd1 << 17);
                c[COEF_D] = rand_within(32'd1 << 21);
            end
            PLANE_WILD: begin
                for (int k = 0; k < 4; k++) c[k] = $urandom;
            end
            default: ;
        endcase
        queue_beat(OP_LOAD, slot, c[COEF_A], c[COEF_B], c[COEF_C], c[COEF_D],
                   $urandom, $urandom);
    endtask

    task automatic queue_random_test();
        logic [OP_W-1:0] op;
        logic signed [31:0] fx, fy, fz, sx, sy, sz;
        op = OP_W'($urandom_range(3, 1));
        fx = rand_coord();
        fy = rand_coord();
        fz = rand_coord();
        sx = $urandom;
        sy = $urandom;
        sz = $urandom;
        if (op == OP_SPHERE) begin
            case ($urandom_range(19))
                0, 1, 2: sx = rand_within(32'd1 << 21) - (32'sd1 << 21);
                3, 4:    sx = $urandom;
                default: sx = $urandom_range(32'd1 << 21);
            endcase
        end else if (op == OP_BOX && $urandom_range(4) != 0) begin
            // Well-ordered box; the remaining fifth keeps arbitrary corners.
            sx = fx + $signed($urandom_range(32'd1 << 20));
            sy = fy + $signed($urandom_range(32'd1 << 20));
            sz = fz + $signed($urandom_range(32'd1 << 20));
        end
        queue_beat(op, $urandom_range(7), fx, fy, fz, sx, sy, sz);
    endtask

    task automatic queue_random_planes();
        int r;
        for (int p = 0; p < PLANES; p++) begin
            r = $urandom_range(9);
            if (r < 2) queue_plane(p, PLANE_ZERO);
            else if (r < 6) queue_plane(p, PLANE_AXIS);
            else if (r < 9) queue_plane(p, PLANE_NEAR);
            else queue_plane(p, PLANE_WILD);
        end
    endtask

    function automatic bit sender_idles();
        if (beats_accepted >= 300 && beats_accepted < 420) return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Driver: offers queued beats, holding a drain-marked beat until no result is due.
    always @(posedge i_clk) begin
        t_cull_beat nb;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                accept_beat(current_beat);
                beats_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_beats.size() != 0 && !sender_idles() &&
                    (!pending_beats[0].wait_drain || visible_expected.size() == 0)) begin
                    nb = pending_beats.pop_front();
                    current_beat = nb;
                    req_if.valid      <= 1'b1;
                    req_if.operation  <= nb.op;
                    req_if.plane_slot <= nb.slot;
                    req_if.first_x    <= nb.fx;
                    req_if.first_y    <= nb.fy;
                    req_if.first_z    <= nb.fz;
                    req_if.second_x   <= nb.sx;
                    req_if.second_y   <= nb.sy;
                    req_if.second_z   <= nb.sz;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives ready, with one long hold-off.
    always @(posedge i_clk) begin
        bit want;
        bit ready_next;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (visible_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: result beat with none expected: expected nothing, got visible=%0b",
                             $time, res_if.visible);
                end else begin
                    want = visible_expected.pop_front();
                    results_checked++;
                    if (res_if.visible) visible_seen++;
                    else culled_seen++;
                    if (res_if.visible !== want) begin
                        error_count++;
                        $display("%0t: visible mismatch on result %0d: expected %0b, got %0b",
                                 $time, results_checked, want, res_if.visible);
                    end
                end
            end
            if (!hold_done && results_checked >= 150) begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (results_checked >= 400 && results_checked < 520) begin
                ready_next = 1'b1;
            end else begin
                ready_next = $urandom_range(99) >= 38;
            end
            res_if.ready <= ready_next;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned target;
        t_cull_beat b;

        req_if.valid = 1'b0;
        req_if.operation = OP_LOAD;
        req_if.plane_slot = '0;
        req_if.first_x = '0;
        req_if.first_y = '0;
        req_if.first_z = '0;
        req_if.second_x = '0;
        req_if.second_y = '0;
        req_if.second_z = '0;
        res_if.ready = 1'b0;
        i_rst_n = 1'b0;
        cycle_count = 0;
        error_count = 0;
        hold_left = 0;
        hold_done = 1'b0;
        for (int p = 0; p < PLANES; p++) plane_coef[p] = '{default: '0};

        // Cleared planes cull nothing, whatever the shape.
        queue_beat(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        queue_beat(OP_BOX, 7, S32MAX, S32MAX, S32MAX, S32MIN, S32MIN, S32MIN);
        queue_beat(OP_SPHERE, 3, S32MIN, S32MIN, S32MIN, S32MIN, 0, 0);
        // Plane x >= 0: the smallest step below zero is culled, zero itself is not.
        queue_beat(OP_LOAD, 0, ONE, 0, 0, 0, 0, 0);
        queue_beat(OP_POINT, 1, -1, 0, 0, 0, 0, 0);
        queue_beat(OP_POINT, 2, 0, S32MAX, S32MIN, 0, 0, 0);
        // Loads past the last plane are dropped.
        queue_beat(OP_LOAD, 7, -ONE, 0, 0, S32MIN, 0, 0);
        queue_beat(OP_LOAD, 6, -ONE, 0, 0, S32MIN, 0, 0);
        queue_beat(OP_POINT, 6, 0, 0, 0, 0, 0, 0);
        // Sphere straddling, touching exactly and clear of the plane.
        queue_beat(OP_SPHERE, 0, -2 * ONE, 0, 0, 3 * ONE, 0, 0);
        queue_beat(OP_SPHERE, 0, -2 * ONE, 0, 0, 2 * ONE, 0, 0);
        queue_beat(OP_SPHERE, 0, -2 * ONE, 0, 0, ONE, 0, 0);
        // Negative radius behaves as a bare point.
        queue_beat(OP_SPHERE, 0, -1, 0, 0, -ONE, 0, 0);
        // Box with min above max takes the given corner, no reordering.
        queue_beat(OP_BOX, 0, 5 * ONE, 0, 0, -5 * ONE, 0, 0);
        queue_beat(OP_BOX, 0, -3 * ONE, 0, 0, 2 * ONE, 0, 0);
        // Negative normal picks the min corner.
        queue_beat(OP_LOAD, 1, -ONE, 0, 0, 0, 0, 0);
        queue_beat(OP_BOX, 0, -3 * ONE, 0, 0, 2 * ONE, 0, 0);
        queue_beat(OP_BOX, 0, ONE, 0, 0, 2 * ONE, 0, 0);
        // Extreme coefficients against extreme coordinates.
        queue_beat(OP_LOAD, 0, 0, 0, 0, 0, 0, 0);
        queue_beat(OP_LOAD, 1, S32MIN, S32MAX, S32MIN, S32MIN, 0, 0);
        queue_beat(OP_POINT, 0, S32MIN, S32MAX, S32MIN, 0, 0, 0);
        queue_beat(OP_POINT, 0, S32MAX, S32MIN, S32MAX, 0, 0, 0);
        queue_beat(OP_SPHERE, 0, S32MAX, S32MIN, S32MAX, S32MAX, 0, 0);
        queue_beat(OP_BOX, 0, S32MIN, S32MIN, S32MIN, S32MAX, S32MAX, S32MAX);
        // A plane with only a negative offset culls everything.
        queue_beat(OP_LOAD, 1, 0, 0, 0, 0, 0, 0);
        queue_beat(OP_LOAD, 5, 0, 0, 0, -1, 0, 0);
        queue_beat(OP_BOX, 7, 0, 0, 0, 0, 0, 0);

        // Random part: plane sets with random shape tests, some noise loads.
        target = pending_beats.size() + RANDOM_BEATS;
        queue_random_planes();
        pending_beats[pending_beats.size() - PLANES].wait_drain = 1'b1;
        while (pending_beats.size() < target) begin
            if ($urandom_range(39) == 0) begin
                queue_random_planes();
            end else if ($urandom_range(29) == 0) begin
                queue_plane($urandom_range(PLANES - 1), t_plane_kind'($urandom_range(3)));
            end else if ($urandom_range(59) == 0) begin
                queue_beat(OP_LOAD, $urandom_range(7, PLANES), $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
            end else begin
                queue_random_test();
            end
            if (pending_beats.size() == 400) begin
                b = pending_beats.pop_back();
                b.wait_drain = 1'b1;
                pending_beats.push_back(b);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || req_if.valid) @(posedge i_clk);
        while (visible_expected.size() != 0) @(posedge i_clk);
        repeat (PLANES + 8 + 16) @(posedge i_clk);

        if (visible_expected.size() != 0) begin
            error_count++;
            $display("%0t: results outstanding at end: expected 0, got %0d",
                     $time, visible_expected.size());
        end

        $display("Covered %0d plane loads (%0d to unused slots) and %0d point, %0d sphere, %0d box tests.",
                 loads_sent, ignored_loads, point_tests, sphere_tests, box_tests);
        $display("Checked %0d results: %0d visible, %0d culled, with a long output stall and a drain pause.",
                 results_checked, visible_seen, culled_seen);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/frc_pkg.sv
hw/rtl/frc_if.sv
hw/rtl/frc_entry.sv
hw/rtl/frc_cell.sv
hw/rtl/frustum_cull_test_unit.sv
dv/frustum_cull_test_unit_tb.sv
